### hdl/gqg_pkg.sv
`timescale 1ns / 1ps

package gqg_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int GLYPH_IDX_W   = $clog2(GLYPH_ENTRIES);

  localparam int CODE_W     = 8;
  localparam int POS_W      = 24;
  localparam int TEX_W      = 17;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // texture divider: 16 quotient bits, two per iteration
  localparam int DIV_BITS  = 16;
  localparam int DIV_RADIX = 2;
  localparam int DIV_ITERS = DIV_BITS / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [TEX_W-1:0] TEX_MAX = 17'h10000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [1:0] CORNER_BR = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_TL = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE    = 3'd0,
    CFG_ATLAS_W  = 3'd1,
    CFG_ATLAS_H  = 3'd2,
    CFG_COLOR    = 3'd3,
    CFG_TEX_SLOT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  advance;
    logic [7:0]  yoffset;
    logic [7:0]  xoffset;
    logic [7:0]  height;
    logic [7:0]  width;
    logic [11:0] y;
    logic [11:0] x;
  } glyph_entry_t;

  typedef struct packed {
    logic       load;
    logic       place;
    logic       set_abort;
    logic       lookup;
    logic       div_step;
    logic       sum;
    logic       emit_vertex;
    logic       emit_error;
    logic       pen_adv;
    logic [1:0] corner;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_place;
    logic aborted_eff;
    logic glyph_hit;
    logic out_free;
  } dp_stat_t;

  localparam logic signed [27:0] POS_MAX = 28'sh07FFFFF;
  localparam logic signed [27:0] POS_MIN = 28'shF800000;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [27:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < POS_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/gqg_div_lane.sv
`timescale 1ns / 1ps

module gqg_div_lane import gqg_pkg::*; (
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [SIZE_W-1:0] texel_i,
  input  logic [SIZE_W-1:0] size_i,
  output logic [TEX_W-1:0]  quot_o
);

  logic [SIZE_W-1:0]   den_q, den_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [DIV_BITS-1:0] quo_q, quo_d;
  logic                sat_q, sat_d;
  logic [SIZE_W-1:0]   den_start;

  // zero atlas size acts as one
  assign den_start = (size_i == '0) ? SIZE_W'(1) : size_i;

  always_comb begin
    logic [SIZE_W-1:0]   r;
    logic [SIZE_W:0]     r2;
    logic [DIV_BITS-1:0] q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    sat_d = sat_q;
    r     = rem_q;
    q     = quo_q;
    r2    = '0;
    if (start_i) begin
      den_d = den_start;
      sat_d = (texel_i >= den_start);
      rem_d = (texel_i >= den_start) ? '0 : texel_i;
      quo_d = '0;
    end else if (step_i) begin
      for (int i = 0; i < DIV_RADIX; i++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, den_q}) begin
          r2 = r2 - {1'b0, den_q};
          q  = {q[DIV_BITS-2:0], 1'b1};
        end else begin
          q  = {q[DIV_BITS-2:0], 1'b0};
        end
        r = r2[SIZE_W-1:0];
      end
      rem_d = r;
      quo_d = q;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign quot_o = sat_q ? TEX_MAX : {1'b0, quo_q};

endmodule

### hdl/gqg_datapath.sv
`timescale 1ns / 1ps

module gqg_datapath import gqg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_stat_t                stat_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    operation_i,
  input  logic [CODE_W-1:0]       char_code_i,
  input  logic [11:0]             glyph_x_i,
  input  logic [11:0]             glyph_y_i,
  input  logic [7:0]              glyph_width_i,
  input  logic [7:0]              glyph_height_i,
  input  logic signed [7:0]       glyph_xoffset_i,
  input  logic signed [7:0]       glyph_yoffset_i,
  input  logic [7:0]              glyph_advance_i,
  input  logic                    start_string_i,
  input  logic signed [POS_W-1:0] start_x_i,
  input  logic signed [POS_W-1:0] start_y_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic signed [POS_W-1:0] vertex_x_o,
  output logic signed [POS_W-1:0] vertex_y_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic [1:0]              corner_o,
  output logic [31:0]             color_out_o,
  output logic [4:0]              texture_out_o,
  output logic                    status_o,
  output logic                    last_o
);

  // configuration
  logic [15:0]       scale_q;
  logic [SIZE_W-1:0] atlas_w_q;
  logic [SIZE_W-1:0] atlas_h_q;
  logic [31:0]       color_q;
  logic [4:0]        slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= 16'd256;
      atlas_w_q <= 13'd256;
      atlas_h_q <= 13'd256;
      color_q   <= 32'hFFFF_FFFF;
      slot_q    <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE:    scale_q   <= cfg_wdata_i[15:0];
        CFG_ATLAS_W:  atlas_w_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_ATLAS_H:  atlas_h_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_COLOR:    color_q   <= cfg_wdata_i;
        CFG_TEX_SLOT: slot_q    <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // glyph table and valid bits
  glyph_entry_t             glyph_mem [GLYPH_ENTRIES];
  glyph_entry_t             rd_q;
  glyph_entry_t             wr_entry;
  logic [GLYPH_ENTRIES-1:0] valid_q;
  logic [GLYPH_IDX_W-1:0]   addr;
  logic                     in_range;

  assign addr     = char_code_i[GLYPH_IDX_W-1:0];
  assign in_range = ({1'b0, char_code_i} < 9'(GLYPH_ENTRIES));

  assign wr_entry = '{
    advance: glyph_advance_i,
    yoffset: glyph_yoffset_i,
    xoffset: glyph_xoffset_i,
    height:  glyph_height_i,
    width:   glyph_width_i,
    y:       glyph_y_i,
    x:       glyph_x_i
  };

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_range) begin
      glyph_mem[addr] <= wr_entry;
    end
    if (cmd_i.place) begin
      rd_q <= glyph_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.load && in_range) begin
      valid_q[addr] <= 1'b1;
    end
  end

  // pen and abort flag
  logic signed [POS_W-1:0] pen_x_q, pen_y_q;
  logic                    aborted_q;
  logic [23:0]             adv_prod_q;
  logic signed [27:0]      pen_adv_sum;

  assign pen_adv_sum = $signed({{4{pen_x_q[POS_W-1]}}, pen_x_q}) + $signed({4'b0, adv_prod_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      aborted_q <= 1'b0;
    end else begin
      if (cmd_i.place && start_string_i) begin
        pen_x_q   <= start_x_i;
        pen_y_q   <= start_y_i;
      end else if (cmd_i.pen_adv) begin
        pen_x_q <= sat_pos(pen_adv_sum);
      end
      if (cmd_i.set_abort) begin
        aborted_q <= 1'b1;
      end else if (cmd_i.place && start_string_i) begin
        aborted_q <= 1'b0;
      end
    end
  end

  // offset products
  logic signed [9:0]  xo_s, yo_s, xr_off, yb_off;
  logic signed [16:0] scale_s;
  logic signed [26:0] prod_xl_q, prod_xr_q, prod_yt_q, prod_yb_q;

  assign xo_s    = {{2{rd_q.xoffset[7]}}, rd_q.xoffset};
  assign yo_s    = {{2{rd_q.yoffset[7]}}, rd_q.yoffset};
  assign xr_off  = xo_s + $signed({2'b00, rd_q.width});
  assign yb_off  = yo_s + $signed({2'b00, rd_q.height});
  assign scale_s = $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      prod_xl_q  <= 27'(xo_s) * 27'(scale_s);
      prod_xr_q  <= 27'(xr_off) * 27'(scale_s);
      prod_yt_q  <= 27'(yo_s) * 27'(scale_s);
      prod_yb_q  <= 27'(yb_off) * 27'(scale_s);
      adv_prod_q <= 24'(rd_q.advance) * 24'(scale_q);
    end
  end

  // screen positions
  function automatic logic signed [27:0] pos_sum(input logic signed [POS_W-1:0] pen,
                                                 input logic signed [26:0] prod);
    return $signed({{4{pen[POS_W-1]}}, pen}) + $signed({prod[26], prod});
  endfunction

  logic signed [POS_W-1:0] xl_q, xr_q, yt_q, yb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      xl_q <= sat_pos(pos_sum(pen_x_q, prod_xl_q));
      xr_q <= sat_pos(pos_sum(pen_x_q, prod_xr_q));
      yt_q <= sat_pos(pos_sum(pen_y_q, prod_yt_q));
      yb_q <= sat_pos(pos_sum(pen_y_q, prod_yb_q));
    end
  end

  // texture coordinates
  logic [SIZE_W-1:0] texel_ul, texel_ur, texel_vt, texel_vb;
  logic [TEX_W-1:0]  ul, ur, vt, vb;

  assign texel_ul = {1'b0, rd_q.x};
  assign texel_ur = {1'b0, rd_q.x} + {5'b0, rd_q.width};
  assign texel_vt = {1'b0, rd_q.y};
  assign texel_vb = {1'b0, rd_q.y} + {5'b0, rd_q.height};

  gqg_div_lane u_div_ul (
    .clk_i   (clk_i),
    .start_i (cmd_i.lookup),
    .step_i  (cmd_i.div_step),
    .texel_i (texel_ul),
    .size_i  (atlas_w_q),
    .quot_o  (ul)
  );

  gqg_div_lane u_div_ur (
    .clk_i   (clk_i),
    .start_i (cmd_i.lookup),
    .step_i  (cmd_i.div_step),
    .texel_i (texel_ur),
    .size_i  (atlas_w_q),
    .quot_o  (ur)
  );

  gqg_div_lane u_div_vt (
    .clk_i   (clk_i),
    .start_i (cmd_i.lookup),
    .step_i  (cmd_i.div_step),
    .texel_i (texel_vt),
    .size_i  (atlas_h_q),
    .quot_o  (vt)
  );

  gqg_div_lane u_div_vb (
    .clk_i   (clk_i),
    .start_i (cmd_i.lookup),
    .step_i  (cmd_i.div_step),
    .texel_i (texel_vb),
    .size_i  (atlas_h_q),
    .quot_o  (vb)
  );

  // output register
  logic right_side, bottom_side;
  logic out_valid_q;

  assign right_side  = (cmd_i.corner == CORNER_BR) || (cmd_i.corner == CORNER_TR);
  assign bottom_side = (cmd_i.corner == CORNER_BR) || (cmd_i.corner == CORNER_BL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_vertex || cmd_i.emit_error) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_vertex) begin
      vertex_x_o    <= right_side ? xr_q : xl_q;
      vertex_y_o    <= bottom_side ? yb_q : yt_q;
      tex_u_o       <= right_side ? ur : ul;
      tex_v_o       <= bottom_side ? vb : vt;
      corner_o      <= cmd_i.corner;
      color_out_o   <= color_q;
      texture_out_o <= slot_q;
      status_o      <= 1'b0;
      last_o        <= (cmd_i.corner == CORNER_BL);
    end else if (cmd_i.emit_error) begin
      vertex_x_o    <= '0;
      vertex_y_o    <= '0;
      tex_u_o       <= '0;
      tex_v_o       <= '0;
      corner_o      <= '0;
      color_out_o   <= '0;
      texture_out_o <= '0;
      status_o      <= 1'b1;
      last_o        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // status to controller
  assign stat_o.op_place    = (operation_i == OP_PLACE);
  assign stat_o.aborted_eff = start_string_i ? 1'b0 : aborted_q;
  assign stat_o.glyph_hit   = in_range && valid_q[addr];
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

### hdl/gqg_ctrl.sv
`timescale 1ns / 1ps

module gqg_ctrl import gqg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_DIV    = 5'b00100,
    S_EMIT   = 5'b01000,
    S_ERR    = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]           corner_q, corner_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    corner_d = corner_q;
    cmd_o    = '0;
    cmd_o.corner = corner_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.op_place) begin
            cmd_o.place = 1'b1;
            if (!stat_i.aborted_eff) begin
              if (stat_i.glyph_hit) begin
                state_d = S_LOOKUP;
              end else begin
                cmd_o.set_abort = 1'b1;
                state_d         = S_ERR;
              end
            end
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        cnt_d        = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.sum      = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          corner_d = CORNER_BR;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_vertex = 1'b1;
          corner_d          = corner_q + 1'b1;
          if (corner_q == CORNER_BL) begin
            cmd_o.pen_adv = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_error = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      corner_q <= CORNER_BR;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      corner_q <= corner_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### hdl/glyph_quad_generator.sv
// load item: no result; the next item can be accepted in the following cycle
// place item: first vertex after the table read, the lookup and 8 two-bit divider
//   steps, one vertex per cycle unless output stalls; next item after the fourth vertex
// missing character: error result, next item once issued; string dropped until a start
// an output stall holds results back; reset (async, active low) clears control, pen, abort flag,
//   glyph valid bits and output valid, config registers take their reset values
`timescale 1ns / 1ps

module glyph_quad_generator import gqg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [CODE_W-1:0]       char_code_i,
  input  logic [11:0]             glyph_x_i,
  input  logic [11:0]             glyph_y_i,
  input  logic [7:0]              glyph_width_i,
  input  logic [7:0]              glyph_height_i,
  input  logic signed [7:0]       glyph_xoffset_i,
  input  logic signed [7:0]       glyph_yoffset_i,
  input  logic [7:0]              glyph_advance_i,
  input  logic                    start_string_i,
  input  logic signed [POS_W-1:0] start_x_i,
  input  logic signed [POS_W-1:0] start_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] vertex_x_o,
  output logic signed [POS_W-1:0] vertex_y_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic [1:0]              corner_o,
  output logic [31:0]             color_out_o,
  output logic [4:0]              texture_out_o,
  output logic                    status_o,
  output logic                    last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gqg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gqg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .glyph_x_i       (glyph_x_i),
    .glyph_y_i       (glyph_y_i),
    .glyph_width_i   (glyph_width_i),
    .glyph_height_i  (glyph_height_i),
    .glyph_xoffset_i (glyph_xoffset_i),
    .glyph_yoffset_i (glyph_yoffset_i),
    .glyph_advance_i (glyph_advance_i),
    .start_string_i  (start_string_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .corner_o        (corner_o),
    .color_out_o     (color_out_o),
    .texture_out_o   (texture_out_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

### hdl/gqg_checker.sv
`timescale 1ns / 1ps

module gqg_checker import gqg_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [POS_W-1:0] vertex_x_o,
  input logic [TEX_W-1:0]        tex_u_o,
  input logic [TEX_W-1:0]        tex_v_o,
  input logic [1:0]              corner_o,
  input logic                    status_o,
  input logic                    last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_x_o) &&
      $stable(corner_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled result changed");

  // error result is a single last transfer with cleared fields
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && vertex_x_o == '0 && tex_u_o == '0 &&
      corner_o == CORNER_BR)
    else $error("malformed error result");

  // only the bottom-left vertex closes a quad
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> (last_o == (corner_o == CORNER_BL)))
    else $error("last flag not on final corner");

  // texture coordinates saturate
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_u_o <= TEX_MAX && tex_v_o <= TEX_MAX)
    else $error("texture coordinate above one");

endmodule

bind glyph_quad_generator gqg_checker u_gqg_checker (.*);

### tb/sv/glyph_quad_checker.sv
`timescale 1ns / 1ps

module glyph_quad_checker import gqg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    operation_i,
  input  logic [CODE_W-1:0]       char_code_i,
  input  logic [11:0]             glyph_x_i,
  input  logic [11:0]             glyph_y_i,
  input  logic [7:0]              glyph_width_i,
  input  logic [7:0]              glyph_height_i,
  input  logic signed [7:0]       glyph_xoffset_i,
  input  logic signed [7:0]       glyph_yoffset_i,
  input  logic [7:0]              glyph_advance_i,
  input  logic                    start_string_i,
  input  logic signed [POS_W-1:0] start_x_i,
  input  logic signed [POS_W-1:0] start_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [POS_W-1:0] vertex_x_i,
  input  logic signed [POS_W-1:0] vertex_y_i,
  input  logic [TEX_W-1:0]        tex_u_i,
  input  logic [TEX_W-1:0]        tex_v_i,
  input  logic [1:0]              corner_i,
  input  logic [31:0]             color_out_i,
  input  logic [4:0]              texture_out_i,
  input  logic                    status_i,
  input  logic                    last_i,
  output int                      err_cnt_o,
  output int                      pend_cnt_o,
  output int                      seen_cnt_o
);

  localparam longint PEN_MAX = 64'sd8388607;
  localparam longint PEN_MIN = -64'sd8388608;

  typedef struct packed {
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
    logic [1:0]              corner;
    logic [31:0]             color;
    logic [4:0]              slot;
    logic                    status;
    logic                    last;
  } vertex_t;

  vertex_t                  vertex_q[$];
  glyph_entry_t             glyph_mem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] glyph_loaded;
  logic [15:0]              scale;
  logic [SIZE_W-1:0]        atlas_w;
  logic [SIZE_W-1:0]        atlas_h;
  logic [31:0]              color;
  logic [4:0]               slot;
  longint                   pen_x;
  longint                   pen_y;
  logic                     aborted;
  int                       errors;
  int                       seen;

  glyph_entry_t             g;
  vertex_t                  vtx;
  vertex_t                  exp_v;
  longint                   sc, xo, yo, gw, gh, adv;
  longint                   xl, xr, yt, yb;
  logic [TEX_W-1:0]         ul, ur, vt, vb;
  logic [1:0]               c;
  logic                     right, bottom;

  function automatic longint clamp_pos(input longint v);
    if (v > PEN_MAX) return PEN_MAX;
    if (v < PEN_MIN) return PEN_MIN;
    return v;
  endfunction

  function automatic logic [TEX_W-1:0] norm_tex(input int unsigned texel,
                                                input logic [SIZE_W-1:0] size);
    longint unsigned d;
    longint unsigned q;
    d = (size == 0) ? 64'd1 : 64'(size);
    q = (64'(texel) << 16) / d;
    return (q > 64'd65536) ? TEX_MAX : q[TEX_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_f,
                             input logic [31:0] act_f);
    if (exp_f !== act_f) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_f, act_f);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_q.delete();
      glyph_loaded = '0;
      scale = 16'd256;
      atlas_w = 13'd256;
      atlas_h = 13'd256;
      color = 32'hFFFF_FFFF;
      slot = 5'd0;
      pen_x = 0;
      pen_y = 0;
      aborted = 1'b0;
      errors = 0;
      seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE:    scale = cfg_wdata_i[15:0];
          CFG_ATLAS_W:  atlas_w = cfg_wdata_i[SIZE_W-1:0];
          CFG_ATLAS_H:  atlas_h = cfg_wdata_i[SIZE_W-1:0];
          CFG_COLOR:    color = cfg_wdata_i;
          CFG_TEX_SLOT: slot = cfg_wdata_i[4:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x=%0h y=%0h status=%0b",
                   $time, vertex_x_i, vertex_y_i, status_i);
          errors++;
        end else begin
          exp_v = vertex_q.pop_front();
          check_field("vertex_x", 32'(exp_v.vx), 32'(vertex_x_i));
          check_field("vertex_y", 32'(exp_v.vy), 32'(vertex_y_i));
          check_field("tex_u", 32'(exp_v.u), 32'(tex_u_i));
          check_field("tex_v", 32'(exp_v.v), 32'(tex_v_i));
          check_field("corner", 32'(exp_v.corner), 32'(corner_i));
          check_field("color_out", exp_v.color, color_out_i);
          check_field("texture_out", 32'(exp_v.slot), 32'(texture_out_i));
          check_field("status", 32'(exp_v.status), 32'(status_i));
          check_field("last", 32'(exp_v.last), 32'(last_i));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_LOAD) begin
          if (int'(char_code_i) < GLYPH_ENTRIES) begin
            g.x = glyph_x_i;
            g.y = glyph_y_i;
            g.width = glyph_width_i;
            g.height = glyph_height_i;
            g.xoffset = glyph_xoffset_i;
            g.yoffset = glyph_yoffset_i;
            g.advance = glyph_advance_i;
            glyph_mem[char_code_i] = g;
            glyph_loaded[char_code_i] = 1'b1;
          end
        end else begin
          if (start_string_i) begin
            pen_x = start_x_i;
            pen_y = start_y_i;
            aborted = 1'b0;
          end
          if (!aborted) begin
            if (int'(char_code_i) >= GLYPH_ENTRIES || !glyph_loaded[char_code_i]) begin
              vtx = '0;
              vtx.status = 1'b1;
              vtx.last = 1'b1;
              vertex_q = {vertex_q, vtx};
              aborted = 1'b1;
            end else begin
              g = glyph_mem[char_code_i];
              sc = scale;
              xo = $signed(g.xoffset);
              yo = $signed(g.yoffset);
              gw = g.width;
              gh = g.height;
              adv = g.advance;
              xl = clamp_pos(pen_x + xo * sc);
              xr = clamp_pos(pen_x + (gw + xo) * sc);
              yt = clamp_pos(pen_y + yo * sc);
              yb = clamp_pos(pen_y + (gh + yo) * sc);
              ul = norm_tex(int'(g.x), atlas_w);
              ur = norm_tex(int'(g.x) + int'(g.width), atlas_w);
              vt = norm_tex(int'(g.y), atlas_h);
              vb = norm_tex(int'(g.y) + int'(g.height), atlas_h);
              for (int k = CORNER_BR; k <= CORNER_BL; k++) begin
                c = 2'(k);
                right = (c == CORNER_BR) || (c == CORNER_TR);
                bottom = (c == CORNER_BR) || (c == CORNER_BL);
                vtx.vx = right ? xr[POS_W-1:0] : xl[POS_W-1:0];
                vtx.vy = bottom ? yb[POS_W-1:0] : yt[POS_W-1:0];
                vtx.u = right ? ur : ul;
                vtx.v = bottom ? vb : vt;
                vtx.corner = c;
                vtx.color = color;
                vtx.slot = slot;
                vtx.status = 1'b0;
                vtx.last = (c == CORNER_BL);
                vertex_q = {vertex_q, vtx};
              end
              pen_x = clamp_pos(pen_x + adv * sc);
            end
          end
        end
      end
    end
    err_cnt_o = errors;
    pend_cnt_o = vertex_q.size();
    seen_cnt_o = seen;
  end

endmodule

### tb/sv/tb_glyph_quad_generator.sv
`timescale 1ns / 1ps

module tb_glyph_quad_generator;
  import gqg_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 95;

  typedef struct {
    logic        op;
    logic [7:0]  code;
    logic [11:0] gx;
    logic [11:0] gy;
    logic [7:0]  gw;
    logic [7:0]  gh;
    logic [7:0]  xo;
    logic [7:0]  yo;
    logic [7:0]  adv;
    logic        start;
    logic [23:0] sx;
    logic [23:0] sy;
  } glyph_item_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    operation;
  logic [CODE_W-1:0]       char_code;
  logic [11:0]             glyph_x;
  logic [11:0]             glyph_y;
  logic [7:0]              glyph_width;
  logic [7:0]              glyph_height;
  logic signed [7:0]       glyph_xoffset;
  logic signed [7:0]       glyph_yoffset;
  logic [7:0]              glyph_advance;
  logic                    start_string;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] vertex_x;
  logic signed [POS_W-1:0] vertex_y;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [1:0]              corner;
  logic [31:0]             color_out;
  logic [4:0]              texture_out;
  logic                    status;
  logic                    last;

  int         err_cnt;
  int         pend_cnt;
  int         seen_cnt;
  bit         idle_on = 1'b1;
  int         hold_tokens = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         items_sent = 0;
  int         settings_cnt = 0;
  bit         str_dead = 1'b0;
  bit         loaded_map [GLYPH_ENTRIES];
  logic [7:0] loaded_codes[$];

  always #5 clk = ~clk;

  glyph_quad_generator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .glyph_x_i       (glyph_x),
    .glyph_y_i       (glyph_y),
    .glyph_width_i   (glyph_width),
    .glyph_height_i  (glyph_height),
    .glyph_xoffset_i (glyph_xoffset),
    .glyph_yoffset_i (glyph_yoffset),
    .glyph_advance_i (glyph_advance),
    .start_string_i  (start_string),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .vertex_x_o      (vertex_x),
    .vertex_y_o      (vertex_y),
    .tex_u_o         (tex_u),
    .tex_v_o         (tex_v),
    .corner_o        (corner),
    .color_out_o     (color_out),
    .texture_out_o   (texture_out),
    .status_o        (status),
    .last_o          (last)
  );

  glyph_quad_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .glyph_x_i       (glyph_x),
    .glyph_y_i       (glyph_y),
    .glyph_width_i   (glyph_width),
    .glyph_height_i  (glyph_height),
    .glyph_xoffset_i (glyph_xoffset),
    .glyph_yoffset_i (glyph_yoffset),
    .glyph_advance_i (glyph_advance),
    .start_string_i  (start_string),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .vertex_x_i      (vertex_x),
    .vertex_y_i      (vertex_y),
    .tex_u_i         (tex_u),
    .tex_v_i         (tex_v),
    .corner_i        (corner),
    .color_out_i     (color_out),
    .texture_out_i   (texture_out),
    .status_i        (status),
    .last_i          (last),
    .err_cnt_o       (err_cnt),
    .pend_cnt_o      (pend_cnt),
    .seen_cnt_o      (seen_cnt)
  );

  function automatic logic [23:0] rand_pos();
    if ($urandom_range(0, 99) < 25) return 24'($urandom);
    return 24'(int'($urandom_range(0, 2000000)) - 1000000);
  endfunction

  function automatic glyph_item_t load_item(input logic [7:0] code, input logic [11:0] gx,
                                            input logic [11:0] gy, input logic [7:0] gw,
                                            input logic [7:0] gh, input logic [7:0] xo,
                                            input logic [7:0] yo, input logic [7:0] adv);
    glyph_item_t it;
    it.op = OP_LOAD;
    it.code = code;
    it.gx = gx;
    it.gy = gy;
    it.gw = gw;
    it.gh = gh;
    it.xo = xo;
    it.yo = yo;
    it.adv = adv;
    it.start = 1'($urandom);
    it.sx = 24'($urandom);
    it.sy = 24'($urandom);
    return it;
  endfunction

  function automatic glyph_item_t rand_load(input logic [7:0] code);
    return load_item(code, 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic glyph_item_t place_item(input logic start, input logic [7:0] code,
                                             input logic [23:0] sx, input logic [23:0] sy);
    glyph_item_t it;
    it = rand_load(code);
    it.op = OP_PLACE;
    it.start = start;
    it.sx = sx;
    it.sy = sy;
    return it;
  endfunction

  task automatic send_glyph_item(input glyph_item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 20);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    char_code <= it.code;
    glyph_x <= it.gx;
    glyph_y <= it.gy;
    glyph_width <= it.gw;
    glyph_height <= it.gh;
    glyph_xoffset <= it.xo;
    glyph_yoffset <= it.yo;
    glyph_advance <= it.adv;
    start_string <= it.start;
    start_x <= it.sx;
    start_y <= it.sy;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    // track which transfers the block acts on
    if (it.op == OP_LOAD) begin
      if (!loaded_map[it.code]) begin
        loaded_map[it.code] = 1'b1;
        loaded_codes = {loaded_codes, it.code};
      end
      items_sent++;
    end else begin
      if (it.start) str_dead = 1'b0;
      if (!str_dead) begin
        items_sent++;
        if (!loaded_map[it.code]) str_dead = 1'b1;
      end
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] scale, input logic [12:0] aw,
                              input logic [12:0] ah, input logic [31:0] col,
                              input logic [4:0] slot);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SCALE;
    cfg_wdata <= 32'(scale);
    @(negedge clk);
    cfg_idx <= CFG_ATLAS_W;
    cfg_wdata <= 32'(aw);
    @(negedge clk);
    cfg_idx <= CFG_ATLAS_H;
    cfg_wdata <= 32'(ah);
    @(negedge clk);
    cfg_idx <= CFG_COLOR;
    cfg_wdata <= col;
    @(negedge clk);
    cfg_idx <= CFG_TEX_SLOT;
    cfg_wdata <= 32'(slot);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [12:0] rand_atlas();
    if ($urandom_range(0, 1) == 0) return 13'(1 << $urandom_range(0, 12));
    return 13'($urandom_range(1, 4096));
  endfunction

  task automatic program_random_regs(input bit wide_scale);
    logic [15:0] scale;
    if (wide_scale) scale = 16'($urandom_range(1, 65535));
    else if ($urandom_range(0, 4) == 0) scale = 16'd256;
    else scale = 16'($urandom_range(32, 1024));
    program_regs(scale, rand_atlas(), rand_atlas(), $urandom, 5'($urandom));
  endtask

  task automatic run_text_phase(input int n_items);
    int         target;
    int         len;
    logic [7:0] code;
    logic       start;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if (loaded_codes.size() == 0 || $urandom_range(0, 99) < 12) begin
        send_glyph_item(rand_load(8'($urandom)));
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 99) < 6) code = 8'($urandom);
          else code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
          // strings mostly open with a start, a few are broken
          if (j == 0) start = ($urandom_range(0, 99) < 90);
          else start = ($urandom_range(0, 99) < 3);
          send_glyph_item(place_item(start, code, rand_pos(), rand_pos()));
        end
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_served < hold_tokens) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SCALE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    operation = OP_LOAD;
    char_code = '0;
    glyph_x = '0;
    glyph_y = '0;
    glyph_width = '0;
    glyph_height = '0;
    glyph_xoffset = '0;
    glyph_yoffset = '0;
    glyph_advance = '0;
    start_string = 1'b0;
    start_x = '0;
    start_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // missing character, then the rest of the string is dropped
    send_glyph_item(place_item(1'b1, 8'd65, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd66, 24'd0, 24'd0));
    send_glyph_item(load_item(8'd65, 12'd0, 12'd0, 8'd8, 8'd12, 8'd0, -8'sd12, 8'd9));
    send_glyph_item(load_item(8'd255, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'sd127, 8'sd127,
                              8'hFF));
    send_glyph_item(load_item(8'd0, 12'd0, 12'd0, 8'd0, 8'd0, -8'sd128, -8'sd128, 8'd0));
    send_glyph_item(place_item(1'b1, 8'd65, 24'd25600, 24'd51200));
    send_glyph_item(place_item(1'b0, 8'd255, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd0, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd65, 24'd0, 24'd0));
    // pen at the extremes so positions saturate
    send_glyph_item(place_item(1'b1, 8'd255, 24'h7FFFFF, 24'h7FFFFF));
    send_glyph_item(place_item(1'b0, 8'd255, 24'h000000, 24'h000000));
    send_glyph_item(place_item(1'b1, 8'd0, 24'h800000, 24'h800000));
    send_glyph_item(place_item(1'b1, 8'd7, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd65, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b1, 8'd65, 24'hFFFF00, 24'h000100));
    settle_block();

    // zero scale and zero atlas size
    program_regs(16'd0, 13'd0, 13'd0, 32'h0000_0000, 5'd31);
    send_glyph_item(place_item(1'b1, 8'd255, rand_pos(), rand_pos()));
    send_glyph_item(place_item(1'b0, 8'd65, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd0, 24'd0, 24'd0));
    settle_block();

    program_regs(16'hFFFF, 13'd4096, 13'd4096, 32'hA5A5_5A5A, 5'd16);
    send_glyph_item(place_item(1'b1, 8'd255, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b0, 8'd0, 24'd0, 24'd0));
    send_glyph_item(place_item(1'b1, 8'd65, 24'd0, 24'd0));
    settle_block();

    program_random_regs(1'b0);
    run_text_phase(PHASE_ITEMS);
    settle_block();

    // output held off while the sender keeps pushing
    program_random_regs(1'b0);
    hold_tokens++;
    run_text_phase(PHASE_ITEMS);
    settle_block();

    idle_on = 1'b0;
    program_random_regs(1'b0);
    run_text_phase(PHASE_ITEMS);
    settle_block();
    idle_on = 1'b1;

    program_random_regs(1'b1);
    run_text_phase(PHASE_ITEMS);
    settle_block();

    $display("run covered %0d loads and placements under %0d register settings",
             items_sent, settings_cnt);
    $display("%0d vertex and missing-character results compared in order", seen_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
